FILE: sv/lfss_pkg.sv
// shared types, codes and constants for the line follow speed selector
// no dependencies

package lfss_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_RATIO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_MIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_MAX        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_MAX        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_SPEED     = 3'd7;

  // item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_MODE  = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;
  localparam logic [1:0] FUNC_ESTOP = 2'd3;

  // drive modes
  localparam logic [1:0] MODE_HOST   = 2'd0;
  localparam logic [1:0] MODE_FOLLOW = 2'd1;
  localparam logic [1:0] MODE_REV    = 2'd2;
  localparam logic [1:0] MODE_STOP   = 2'd3;

  localparam int unsigned CENTER_PIXEL_DEF = 64;

  // fixed divisors of the speed law
  localparam logic [8:0] VEL_DIV    = 9'd120;
  localparam logic [8:0] CREEP_DIV  = 9'd10;
  localparam logic [8:0] RATIO_BIAS = 9'd2;

  // shared divider widths
  localparam int unsigned DIVD_W = 17;
  localparam int unsigned DIVS_W = 9;

  // rounded-up reciprocals for the fixed divisions, exact for any 17-bit dividend
  localparam int unsigned RCP_SHIFT = 24;
  localparam int unsigned RCP_W     = 22;
  localparam logic [RCP_W-1:0] RCP_VEL =
    RCP_W'(((1 << RCP_SHIFT) + int'(VEL_DIV) - 1) / int'(VEL_DIV));
  localparam logic [RCP_W-1:0] RCP_CREEP =
    RCP_W'(((1 << RCP_SHIFT) + int'(CREEP_DIV) - 1) / int'(CREEP_DIV));

  typedef struct packed {
    logic [7:0]  width_min;
    logic [7:0]  width_max;
    logic [7:0]  critical_ratio;
    logic [6:0]  pos_min;
    logic [6:0]  pos_max;
    logic [9:0]  ang_max;
    logic [7:0]  lost_limit;
    logic [14:0] back_speed;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/lfss_ifs.sv
// valid/ready channel interfaces for items and results
// no dependencies

interface lfss_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [7:0]        line_width;
  logic [6:0]        line_position;
  logic [1:0]        new_mode;
  logic signed [15:0] host_velocity;
  logic signed [15:0] host_angular;

  modport source (output valid, func, line_width, line_position, new_mode,
                  host_velocity, host_angular, input ready);
  modport sink (input valid, func, line_width, line_position, new_mode,
                host_velocity, host_angular, output ready);
endinterface

interface lfss_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] velocity;
  logic signed [15:0] angular;
  logic [1:0]         mode_out;

  modport source (output valid, velocity, angular, mode_out, input ready);
  modport sink (input valid, velocity, angular, mode_out, output ready);
endinterface

FILE: sv/line_follow_speed_select.sv
// drive command selector: set-mode, load and stop items finish at acceptance; a tick with
// no arithmetic goes through S_EMIT, which waits for a free output register. a line-follow
// tick with the line seen runs a threshold multiply, a 17-step threshold division and one
// reciprocal multiply, two inside the steering window (S_THR_MUL to S_ANG_GO, then S_EMIT);
// input is not ready until the result is in the output register; a waiting result does not block input.
// synchronous active-low reset: default config, host mode, zero host speeds, output empty

module line_follow_speed_select #(
  parameter int unsigned CENTER_PIXEL = lfss_pkg::CENTER_PIXEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lfss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lfss_in_if.sink                         in_ch,
  lfss_out_if.source                      out_ch
);
  import lfss_pkg::*;

  localparam logic [7:0] CP = 8'(CENTER_PIXEL);
  localparam logic [RCP_W-1:0] RCP_CP =
    RCP_W'(((1 << RCP_SHIFT) + CENTER_PIXEL - 1) / CENTER_PIXEL);

  typedef enum logic [3:0] {
    S_IDLE, S_THR_MUL, S_THR_GO, S_THR_WAIT, S_VEL_PREP, S_VEL_GO,
    S_ANG_PREP, S_ANG_GO, S_EMIT
  } state_t;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [7:0]         lost_r, lost_nxt;
  logic               appr_r, appr_nxt;
  logic signed [15:0] hvel_r, hvel_nxt;
  logic signed [15:0] hang_r, hang_nxt;
  logic [7:0]         w_r, w_nxt;
  logic [6:0]         pos_r, pos_nxt;
  logic [7:0]         thr_r, thr_nxt;
  logic [DIVD_W-1:0]  prod_r, prod_nxt;
  logic [DIVS_W-1:0]  den_r, den_nxt;
  logic [RCP_W-1:0]   rcp_r, rcp_nxt;
  logic signed [15:0] vel_r, vel_nxt;
  logic signed [15:0] ang_r, ang_nxt;
  logic               ovld_r, ovld_nxt;
  logic signed [15:0] ovel_r, ovel_nxt;
  logic signed [15:0] oang_r, oang_nxt;
  logic [1:0]         omode_r, omode_nxt;

  logic                    accept;
  logic                    seen;
  logic [7:0]              cnt_inc;
  logic signed [8:0]       off;
  logic [8:0]              off_mag;
  logic [7:0]              abs_off;
  logic [8:0]              ctr9;
  logic [7:0]              ctr;
  logic                    in_window;
  logic [DIVD_W-1:0]       mul_a;
  logic [RCP_W-1:0]        mul_b;
  logic [DIVD_W+RCP_W-1:0] mul_p;
  logic [15:0]             q16;

  lfss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign seen    = (in_ch.line_width > cfg.width_min) && (in_ch.line_width < cfg.width_max);
  assign cnt_inc = (lost_r != 8'hFF) ? lost_r + 8'd1 : lost_r;

  // offset of the line from centre and the clamped centre term
  always_comb begin
    off     = $signed({1'b0, CP}) - $signed({2'b00, pos_r});
    off_mag = off[8] ? 9'(-off) : 9'(off);
    abs_off = off_mag[7:0];
    ctr9    = {1'b0, CP} - {1'b0, abs_off};
    ctr     = ctr9[8] ? 8'd0 : ctr9[7:0];
  end

  assign in_window = (pos_r < cfg.pos_max) && (pos_r > cfg.pos_min);

  // the one multiplier, operands picked by the sequencer step
  always_comb begin
    case (state_r)
      S_THR_MUL: begin
        mul_a = {9'd0, cfg.width_max};
        mul_b = {14'd0, cfg.critical_ratio};
      end
      S_VEL_PREP: begin
        mul_a = {9'd0, 8'(cfg.width_max - w_r)};
        mul_b = {14'd0, ctr};
      end
      S_ANG_PREP: begin
        mul_a = {7'd0, cfg.ang_max};
        mul_b = {14'd0, abs_off};
      end
      default: begin
        // fixed division as a multiply by the reciprocal
        mul_a = prod_r;
        mul_b = rcp_r;
      end
    endcase
    mul_p = {{RCP_W{1'b0}}, mul_a} * {{DIVD_W{1'b0}}, mul_b};
  end

  assign q16 = {1'b0, mul_p[RCP_SHIFT+14:RCP_SHIFT]};

  always_comb begin
    div_req.start    = (state_r == S_THR_GO);
    div_req.dividend = prod_r;
    div_req.divisor  = den_r;
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    lost_nxt  = lost_r;
    appr_nxt  = appr_r;
    hvel_nxt  = hvel_r;
    hang_nxt  = hang_r;
    w_nxt     = w_r;
    pos_nxt   = pos_r;
    thr_nxt   = thr_r;
    prod_nxt  = prod_r;
    den_nxt   = den_r;
    rcp_nxt   = rcp_r;
    vel_nxt   = vel_r;
    ang_nxt   = ang_r;
    ovld_nxt  = ovld_r;
    ovel_nxt  = ovel_r;
    oang_nxt  = oang_r;
    omode_nxt = omode_r;

    if (ovld_r && out_ch.ready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.func)
            FUNC_MODE: begin
              if (in_ch.new_mode != MODE_STOP) begin
                mode_nxt = in_ch.new_mode;
              end
            end
            FUNC_LOAD: begin
              hvel_nxt = in_ch.host_velocity;
              hang_nxt = in_ch.host_angular;
            end
            FUNC_ESTOP: begin
              hvel_nxt = '0;
              hang_nxt = '0;
            end
            default: begin
              state_nxt = S_EMIT;
              case (mode_r)
                MODE_FOLLOW: begin
                  w_nxt   = in_ch.line_width;
                  pos_nxt = in_ch.line_position;
                  vel_nxt = '0;
                  ang_nxt = '0;
                  if (seen) begin
                    lost_nxt  = '0;
                    state_nxt = S_THR_MUL;
                  end else if (appr_r) begin
                    mode_nxt = MODE_HOST;
                    appr_nxt = 1'b0;
                  end else if (cnt_inc > cfg.lost_limit) begin
                    mode_nxt = MODE_STOP;
                    lost_nxt = '0;
                  end else begin
                    lost_nxt = cnt_inc;
                  end
                end
                MODE_REV: begin
                  vel_nxt = -$signed({1'b0, cfg.back_speed});
                  ang_nxt = '0;
                end
                MODE_HOST: begin
                  vel_nxt = hvel_r;
                  ang_nxt = hang_r;
                end
                default: begin
                  vel_nxt = '0;
                  ang_nxt = '0;
                end
              endcase
            end
          endcase
        end
      end
      S_THR_MUL: begin
        prod_nxt  = mul_p[DIVD_W-1:0];
        den_nxt   = {1'b0, cfg.critical_ratio} + RATIO_BIAS;
        state_nxt = S_THR_GO;
      end
      S_THR_GO:   state_nxt = S_THR_WAIT;
      S_THR_WAIT: begin
        if (div_rsp.done) begin
          thr_nxt   = div_rsp.quotient[7:0];
          state_nxt = S_VEL_PREP;
        end
      end
      S_VEL_PREP: begin
        // wide line: creep speed and mark the approach
        if (w_r > thr_r) begin
          prod_nxt = {9'd0, 8'(cfg.width_max - thr_r)};
          rcp_nxt  = RCP_CREEP;
          appr_nxt = 1'b1;
        end else begin
          prod_nxt = mul_p[DIVD_W-1:0];
          rcp_nxt  = RCP_VEL;
        end
        state_nxt = S_VEL_GO;
      end
      S_VEL_GO: begin
        vel_nxt   = q16;
        state_nxt = S_ANG_PREP;
      end
      S_ANG_PREP: begin
        if (in_window) begin
          prod_nxt  = mul_p[DIVD_W-1:0];
          rcp_nxt   = RCP_CP;
          state_nxt = S_ANG_GO;
        end else begin
          ang_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_ANG_GO: begin
        // magnitude divided, sign put back: truncation toward zero
        ang_nxt   = off[8] ? -$signed(q16) : $signed(q16);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt  = 1'b1;
          ovel_nxt  = vel_r;
          oang_nxt  = ang_r;
          omode_nxt = mode_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_HOST;
      lost_r  <= '0;
      appr_r  <= 1'b0;
      hvel_r  <= '0;
      hang_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      lost_r  <= lost_nxt;
      appr_r  <= appr_nxt;
      hvel_r  <= hvel_nxt;
      hang_r  <= hang_nxt;
      ovld_r  <= ovld_nxt;
      w_r     <= w_nxt;
      pos_r   <= pos_nxt;
      thr_r   <= thr_nxt;
      prod_r  <= prod_nxt;
      den_r   <= den_nxt;
      rcp_r   <= rcp_nxt;
      vel_r   <= vel_nxt;
      ang_r   <= ang_nxt;
      ovel_r  <= ovel_nxt;
      oang_r  <= oang_nxt;
      omode_r <= omode_nxt;
    end
  end

  assign out_ch.valid    = ovld_r;
  assign out_ch.velocity = ovel_r;
  assign out_ch.angular  = oang_r;
  assign out_ch.mode_out = omode_r;

endmodule

FILE: sv/lfss_cfg_regs.sv
// configuration register file with write-only port
// depends on lfss_pkg

module lfss_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lfss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lfss_pkg::cfg_t                 cfg
);
  import lfss_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_min      <= 8'd10;
      cfg_r.width_max      <= 8'd100;
      cfg_r.critical_ratio <= 8'd8;
      cfg_r.pos_min        <= 7'd4;
      cfg_r.pos_max        <= 7'd124;
      cfg_r.ang_max        <= 10'd300;
      cfg_r.lost_limit     <= 8'd50;
      cfg_r.back_speed     <= 15'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_MIN:      cfg_r.width_min      <= cfg_wdata[7:0];
        CFG_WIDTH_MAX:      cfg_r.width_max      <= cfg_wdata[7:0];
        CFG_CRITICAL_RATIO: cfg_r.critical_ratio <= cfg_wdata[7:0];
        CFG_POS_MIN:        cfg_r.pos_min        <= cfg_wdata[6:0];
        CFG_POS_MAX:        cfg_r.pos_max        <= cfg_wdata[6:0];
        CFG_ANG_MAX:        cfg_r.ang_max        <= cfg_wdata[9:0];
        CFG_LOST_LIMIT:     cfg_r.lost_limit     <= cfg_wdata[7:0];
        CFG_BACK_SPEED:     cfg_r.back_speed     <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/lfss_div.sv
// restoring divider, one quotient bit per cycle
// depends on lfss_pkg

module lfss_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lfss_pkg::div_req_t req,
  output lfss_pkg::div_rsp_t rsp
);
  import lfss_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] den_r;
  logic [DIVS_W-1:0] rem_r;

  logic [DIVS_W:0]   shf;
  logic              ge;
  logic [DIVS_W-1:0] rem_nxt;
  logic [DIVD_W-1:0] quo_nxt;

  always_comb begin
    shf     = {rem_r, quo_r[DIVD_W-1]};
    ge      = shf >= {1'b0, den_r};
    rem_nxt = ge ? DIVS_W'(shf - {1'b0, den_r}) : shf[DIVS_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        quo_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(DIVD_W - 1);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: sv/lfss_chk.sv
// port-level checker for the drive command selector, bound to the top level
// depends on lfss_pkg and line_follow_speed_select

module lfss_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_velocity,
  input logic [15:0] out_angular,
  input logic [1:0]  out_mode
);
  import lfss_pkg::*;

  // a waiting beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_velocity) &&
    $stable(out_angular) && $stable(out_mode))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode == MODE_STOP) |-> (out_velocity == '0) && (out_angular == '0))
    else $error("nonzero command in stop mode");

  a_rev_straight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode == MODE_REV) |-> (out_angular == '0))
    else $error("steering in reverse mode");

  a_follow_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode == MODE_FOLLOW) |-> !out_velocity[15])
    else $error("negative speed in line follow");

endmodule

bind line_follow_speed_select lfss_chk u_lfss_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_velocity (out_ch.velocity),
  .out_angular  (out_ch.angular),
  .out_mode     (out_ch.mode_out)
);
